### rtl/stack_permutation_checker_assert.svh
// Assertion macros for the checker file of the stack permutation checker.
// Each macro expects signals named clk and rst_n in the scope where it is used.
`ifndef STACK_PERMUTATION_CHECKER_ASSERT_SVH
`define STACK_PERMUTATION_CHECKER_ASSERT_SVH

// A property that must hold at every rising clock edge outside reset.
`define SPC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must never be seen outside reset.
`define SPC_ASSERT_NEVER(label, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

### rtl/spc_pkg.sv
// Shared types and constants for the stack permutation checker.
// No dependencies; imported by every module of the block.
package spc_pkg;

    localparam int MAX_CARS_DEF = 16;
    localparam int CAR_W        = 8;
    localparam int OP_W         = 2;
    localparam int OUT_TDATA_W  = 8;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_PUSH       = 2'd0;
    localparam op_t OP_POP        = 2'd1;
    localparam op_t OP_IMPOSSIBLE = 2'd2;

    localparam logic FUNC_ARRIVAL = 1'b0;
    localparam logic FUNC_WANTED  = 1'b1;

endpackage

### rtl/spc_ram.sv
// Simple dual-port car memory: one write port, one read port with registered data.
// Depends on spc_pkg for the car width.
module spc_ram
    import spc_pkg::*;
#(
    parameter int DEPTH = MAX_CARS_DEF,
    parameter int AW    = 4
)
(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [CAR_W-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [CAR_W-1:0] rdata
);

    logic [CAR_W-1:0] mem [DEPTH];
    logic [CAR_W-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

### rtl/spc_seq.sv
// Load and replay sequencer of the stack permutation checker.
// Depends on spc_pkg; drives the three car memories held in spc_ram instances.
module spc_seq
    import spc_pkg::*;
#(
    parameter int MAX_CARS = MAX_CARS_DEF,
    parameter int AW       = 4,
    parameter int CW       = 5
)
(
    input  logic             clk,
    input  logic             rst_n,
    // load side
    input  logic             in_valid,
    output logic             in_ready,
    input  logic             in_func,
    input  logic [CAR_W-1:0] in_car,
    input  logic             in_last,
    // result side
    output logic             out_valid,
    input  logic             out_ready,
    output op_t              out_op,
    output logic             out_final,
    // memory ports
    output logic [CAR_W-1:0] car_wdata,
    output logic             arr_we,
    output logic [AW-1:0]    arr_waddr,
    output logic [AW-1:0]    arr_raddr,
    input  logic [CAR_W-1:0] arr_rdata,
    output logic             wnt_we,
    output logic [AW-1:0]    wnt_waddr,
    output logic [AW-1:0]    wnt_raddr,
    input  logic [CAR_W-1:0] wnt_rdata,
    output logic             stk_we,
    output logic [AW-1:0]    stk_waddr,
    output logic [CAR_W-1:0] stk_wdata,
    output logic [AW-1:0]    stk_raddr,
    input  logic [CAR_W-1:0] stk_rdata
);

    localparam logic [1:0] ST_LOAD = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_EVAL = 2'd2;

    localparam logic [CW-1:0] MAX_C = CW'(MAX_CARS);
    localparam logic [CW-1:0] ONE_C = CW'(1);

    logic [1:0]    state_reg, state_next;
    logic [CW-1:0] arr_cnt_reg, arr_cnt_next;
    logic [CW-1:0] wnt_cnt_reg, wnt_cnt_next;
    logic [CW-1:0] arr_nxt_reg, arr_nxt_next;
    logic [CW-1:0] wnt_nxt_reg, wnt_nxt_next;
    logic [CW-1:0] depth_reg, depth_next;
    logic          out_valid_reg, out_valid_next;
    op_t           op_reg, op_next;
    logic          final_reg, final_next;

    logic          load_fire;
    logic          step_fire;
    logic          can_pop;
    logic          can_push;
    logic [CW-1:0] depth_m1;
    logic [CW-1:0] wnt_inc;

    assign in_ready  = (state_reg == ST_LOAD);
    assign load_fire = in_valid && in_ready;

    // A step only commits when the output register is free or being emptied.
    assign step_fire = (state_reg == ST_EVAL) && (!out_valid_reg || out_ready);

    assign depth_m1 = depth_reg - ONE_C;
    assign wnt_inc  = wnt_nxt_reg + ONE_C;

    assign can_pop  = (depth_reg != '0) && (stk_rdata == wnt_rdata);
    assign can_push = (arr_nxt_reg < arr_cnt_reg) && (depth_reg < MAX_C);

    // Reads are issued every cycle from the current pointers; the READ state
    // lets the registered data catch up after an update.
    assign arr_raddr = arr_nxt_reg[AW-1:0];
    assign wnt_raddr = wnt_nxt_reg[AW-1:0];
    assign stk_raddr = depth_m1[AW-1:0];

    assign car_wdata = in_car;
    assign arr_we    = load_fire && (in_func == FUNC_ARRIVAL) && (arr_cnt_reg < MAX_C);
    assign arr_waddr = arr_cnt_reg[AW-1:0];
    assign wnt_we    = load_fire && (in_func == FUNC_WANTED) && (wnt_cnt_reg < MAX_C);
    assign wnt_waddr = wnt_cnt_reg[AW-1:0];
    assign stk_we    = step_fire && !can_pop && can_push;
    assign stk_waddr = depth_reg[AW-1:0];
    assign stk_wdata = arr_rdata;

    always_comb
    begin
        state_next     = state_reg;
        arr_cnt_next   = arr_cnt_reg;
        wnt_cnt_next   = wnt_cnt_reg;
        arr_nxt_next   = arr_nxt_reg;
        wnt_nxt_next   = wnt_nxt_reg;
        depth_next     = depth_reg;
        out_valid_next = out_valid_reg && !out_ready;
        op_next        = op_reg;
        final_next     = final_reg;

        unique case (state_reg)
            ST_LOAD:
            begin
                if (arr_we)
                begin
                    arr_cnt_next = arr_cnt_reg + ONE_C;
                end
                if (wnt_we)
                begin
                    wnt_cnt_next = wnt_cnt_reg + ONE_C;
                end
                if (load_fire && (in_func == FUNC_WANTED) && in_last)
                begin
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (step_fire)
                begin
                    out_valid_next = 1'b1;
                    state_next     = ST_READ;
                    if (can_pop)
                    begin
                        op_next      = OP_POP;
                        final_next   = (wnt_inc == wnt_cnt_reg);
                        depth_next   = depth_m1;
                        wnt_nxt_next = wnt_inc;
                    end
                    else if (can_push)
                    begin
                        op_next      = OP_PUSH;
                        final_next   = 1'b0;
                        depth_next   = depth_reg + ONE_C;
                        arr_nxt_next = arr_nxt_reg + ONE_C;
                    end
                    else
                    begin
                        op_next    = OP_IMPOSSIBLE;
                        final_next = 1'b1;
                    end
                    // The run is over: start the next one from empty sequences.
                    if (final_next)
                    begin
                        state_next   = ST_LOAD;
                        arr_cnt_next = '0;
                        wnt_cnt_next = '0;
                        arr_nxt_next = '0;
                        wnt_nxt_next = '0;
                        depth_next   = '0;
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_LOAD;
            arr_cnt_reg   <= '0;
            wnt_cnt_reg   <= '0;
            arr_nxt_reg   <= '0;
            wnt_nxt_reg   <= '0;
            depth_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            arr_cnt_reg   <= arr_cnt_next;
            wnt_cnt_reg   <= wnt_cnt_next;
            arr_nxt_reg   <= arr_nxt_next;
            wnt_nxt_reg   <= wnt_nxt_next;
            depth_reg     <= depth_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg    <= op_next;
        final_reg <= final_next;
    end

    assign out_valid = out_valid_reg;
    assign out_op    = op_reg;
    assign out_final = final_reg;

endmodule

### rtl/stack_permutation_checker.sv
// Stack permutation checker: load a train's arrival and wanted departure order
// and replay them through one siding stack. Depends on spc_pkg, spc_seq, spc_ram.
//
// Usage. Cars arrive as beats on the s_axis channel. The tuser bit selects the
// sequence: 0 appends the car in tdata to the arrival order, 1 appends it to the
// wanted departure order. Each sequence holds up to MAX_CARS cars; further cars
// are dropped. A wanted beat with tlast set starts the check, which replays the
// cars through the stack and sends one beat per step on m_axis: push, pop, or
// impossible. The final beat of a check carries tlast, and then the block is
// empty again, ready for the next train.
// Timing. s_axis_tready is high while loading and low while a check runs.
// Each check step reads arrival, wanted and stack top from the car memories
// in the READ state (registered read data), then decides and updates in the
// EVAL state, whose result goes to a registered output. If the receiver holds
// m_axis_tready low, the step waits on the one-deep output register; loading
// resumes while the last result of a check is still waiting there.
// Reset. rst_n clears all counts, the stack depth and the output valid; memory
// contents are not cleared, since only entries written in the current run are read.
module stack_permutation_checker
    import spc_pkg::*;
#(
    parameter int MAX_CARS = MAX_CARS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [CAR_W-1:0]       s_axis_tdata,   // [7:0] car
    input  logic                   s_axis_tuser,   // [0] func: 0 arrival, 1 wanted
    input  logic                   s_axis_tlast,   // last wanted car, starts the check
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // [1:0] op, [7:2] zero
    output logic                   m_axis_tlast    // final result of the check
);

    // Address and count widths follow the capacity.
    localparam int AW = (MAX_CARS > 1) ? $clog2(MAX_CARS) : 1;
    localparam int CW = $clog2(MAX_CARS + 1);

    logic [CAR_W-1:0] car_wdata;
    logic             arr_we, wnt_we, stk_we;
    logic [AW-1:0]    arr_waddr, wnt_waddr, stk_waddr;
    logic [AW-1:0]    arr_raddr, wnt_raddr, stk_raddr;
    logic [CAR_W-1:0] arr_rdata, wnt_rdata, stk_rdata, stk_wdata;
    op_t              res_op;

    spc_seq #(
        .MAX_CARS (MAX_CARS),
        .AW       (AW),
        .CW       (CW)
    ) u_seq (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_ready  (s_axis_tready),
        .in_func   (s_axis_tuser),
        .in_car    (s_axis_tdata),
        .in_last   (s_axis_tlast),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_op    (res_op),
        .out_final (m_axis_tlast),
        .car_wdata (car_wdata),
        .arr_we    (arr_we),
        .arr_waddr (arr_waddr),
        .arr_raddr (arr_raddr),
        .arr_rdata (arr_rdata),
        .wnt_we    (wnt_we),
        .wnt_waddr (wnt_waddr),
        .wnt_raddr (wnt_raddr),
        .wnt_rdata (wnt_rdata),
        .stk_we    (stk_we),
        .stk_waddr (stk_waddr),
        .stk_wdata (stk_wdata),
        .stk_raddr (stk_raddr),
        .stk_rdata (stk_rdata)
    );

    // Arrival order.
    spc_ram #(
        .DEPTH (MAX_CARS),
        .AW    (AW)
    ) u_arr_ram (
        .clk   (clk),
        .we    (arr_we),
        .waddr (arr_waddr),
        .wdata (car_wdata),
        .raddr (arr_raddr),
        .rdata (arr_rdata)
    );

    // Wanted departure order.
    spc_ram #(
        .DEPTH (MAX_CARS),
        .AW    (AW)
    ) u_wnt_ram (
        .clk   (clk),
        .we    (wnt_we),
        .waddr (wnt_waddr),
        .wdata (car_wdata),
        .raddr (wnt_raddr),
        .rdata (wnt_rdata)
    );

    // Siding stack. A push writes in the decide cycle and the next read of the
    // top happens only after the following read cycle, so no forwarding is needed.
    spc_ram #(
        .DEPTH (MAX_CARS),
        .AW    (AW)
    ) u_stk_ram (
        .clk   (clk),
        .we    (stk_we),
        .waddr (stk_waddr),
        .wdata (stk_wdata),
        .raddr (stk_raddr),
        .rdata (stk_rdata)
    );

    assign m_axis_tdata = {{(OUT_TDATA_W - OP_W){1'b0}}, res_op};

endmodule

### rtl/spc_checker.sv
// Port-level checker for the stack permutation checker, bound to the top level.
// Depends on spc_pkg and on the macros in stack_permutation_checker_assert.svh.
`include "stack_permutation_checker_assert.svh"

module spc_checker
    import spc_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic [CAR_W-1:0]       s_axis_tdata,
    input logic                   s_axis_tuser,
    input logic                   s_axis_tlast,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tlast
);

    logic in_beat;

    assign in_beat = s_axis_tvalid && s_axis_tready && (s_axis_tdata == s_axis_tdata)
                     && (s_axis_tuser == s_axis_tuser) && (s_axis_tlast == s_axis_tlast);

    // A stalled result beat holds still.
    `SPC_ASSERT(a_out_hold, m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast), "result beat changed while stalled")

    // An impossible verdict always ends the check.
    `SPC_ASSERT(a_imp_final, m_axis_tvalid && (m_axis_tdata[OP_W-1:0] == OP_IMPOSSIBLE) |-> m_axis_tlast, "impossible result not marked final")

    // A push is always followed by another step, so it never ends a check.
    `SPC_ASSERT_NEVER(a_push_final, m_axis_tvalid && m_axis_tlast && (m_axis_tdata[OP_W-1:0] == OP_PUSH), "push result marked final")

    // Just after the beat that starts a check, no car is taken in.
    `SPC_ASSERT_NEVER(a_no_load_in_check, $past(in_beat && s_axis_tuser && s_axis_tlast) && s_axis_tready, "load accepted right after check start")

endmodule

bind stack_permutation_checker spc_checker u_spc_checker (.*);
